FILE: src/hpm_pkg.sv
package hpm_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROW0_PAIR = 3'd0,
    REG_H02_H10   = 3'd1,
    REG_H11_H12   = 3'd2,
    REG_H20_H21   = 3'd3,
    REG_H22       = 3'd4,
    REG_FRAC_BITS = 3'd5,
    REG_SWAP      = 3'd6
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } map_status_t;

  localparam int unsigned DIV_STEPS = 33;
  localparam logic [63:0] IDENT_PAIR = 64'h0001_0000_0000_0000;
  localparam logic [31:0] IDENT_ONE  = 32'h0001_0000;

endpackage

FILE: src/homography_point_map.sv
// Throughput: one point per cycle; busy is low except during reset.
// The depth is set by the 33-stage restoring divider, one quotient bit per stage.
// Reset (synchronous, active low) clears all pipeline valid bits and loads the
// identity matrix at 16 fraction bits. The receiver cannot stall the pipeline.
module homography_point_map #(
  parameter int IN_FRAC    = 8,
  parameter int OUT_FRAC   = 16,
  parameter int COEF_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_first,
  input  logic signed [31:0]   in_second,
  output logic                 out_valid,
  output logic signed [31:0]   out_first,
  output logic signed [31:0]   out_second,
  output hpm_pkg::map_status_t map_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import hpm_pkg::*;

  localparam int NW = 64 + OUT_FRAC;

  logic [63:0] row0_r, h02h10_r, h11h12_r, h20h21_r;
  logic [31:0] h22_r;
  logic        swap_r;

  // Configuration writes; the port never stalls.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r      <= IDENT_PAIR;
      h02h10_r    <= '0;
      h11h12_r    <= IDENT_PAIR;
      h20h21_r    <= '0;
      h22_r       <= IDENT_ONE;
      swap_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0_PAIR: row0_r      <= cfg_data;
        REG_H02_H10:   h02h10_r    <= cfg_data;
        REG_H11_H12:   h11h12_r    <= cfg_data;
        REG_H20_H21:   h20h21_r    <= cfg_data;
        REG_H22:       h22_r       <= cfg_data[31:0];
        // The coefficient fraction count cancels in the quotient and is not kept.
        REG_FRAC_BITS: ;
        REG_SWAP:      swap_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] coef_of(input logic [31:0] slot);
    logic [COEF_WIDTH-1:0] c;
    c = slot[COEF_WIDTH-1:0];
    return 32'(signed'(c));
  endfunction

  logic signed [31:0] h [9];
  always_comb begin
    h[0] = coef_of(row0_r[63:32]);
    h[1] = coef_of(row0_r[31:0]);
    h[2] = coef_of(h02h10_r[63:32]);
    h[3] = coef_of(h02h10_r[31:0]);
    h[4] = coef_of(h11h12_r[63:32]);
    h[5] = coef_of(h11h12_r[31:0]);
    h[6] = coef_of(h20h21_r[63:32]);
    h[7] = coef_of(h20h21_r[31:0]);
    h[8] = coef_of(h22_r);
  end

  // Acceptance is open whenever the block is out of reset.
  assign busy = !rst_n;
  logic in_fire;
  assign in_fire = start && !busy;

  // Stage 1: register the point.
  logic               v1_r;
  logic signed [31:0] a_r, b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_fire;
    a_r <= in_first;
    b_r <= in_second;
  end

  // Stage 2: six products plus three offset terms.
  logic               v2_r;
  logic signed [63:0] pa_r [3];
  logic signed [63:0] pb_r [3];
  logic signed [65:0] pc_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    for (int r = 0; r < 3; r++) begin
      pa_r[r] <= 64'(h[3*r]) * 64'(a_r);
      pb_r[r] <= 64'(h[3*r+1]) * 64'(b_r);
      pc_r[r] <= 66'(h[3*r+2]) <<< IN_FRAC;
    end
  end

  // Stage 3: exact three-term sums.
  logic               v3_r;
  logic signed [65:0] s_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    for (int r = 0; r < 3; r++) begin
      s_r[r] <= 66'(pa_r[r]) + 66'(pb_r[r]) + pc_r[r];
    end
  end

  // Stage 4: sign and magnitude.
  logic        v4_r;
  logic [63:0] m_r [3];
  logic        n_r [3];
  always_ff @(posedge clk) begin
    logic [65:0] t;
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    for (int r = 0; r < 3; r++) begin
      t = s_r[r][65] ? 66'(-s_r[r]) : 66'(s_r[r]);
      m_r[r] <= t[63:0];
      n_r[r] <= s_r[r][65];
    end
  end

  // Divider pipeline registers, index k holds the state after k quotient bits.
  logic        dv_r   [DIV_STEPS+1];
  logic [63:0] d_r    [DIV_STEPS+1];
  logic [63:0] xrem_r [DIV_STEPS+1];
  logic [63:0] yrem_r [DIV_STEPS+1];
  logic [32:0] xlo_r  [DIV_STEPS+1];
  logic [32:0] ylo_r  [DIV_STEPS+1];
  logic [32:0] xq_r   [DIV_STEPS+1];
  logic [32:0] yq_r   [DIV_STEPS+1];
  logic        xpre_r [DIV_STEPS+1];
  logic        ypre_r [DIV_STEPS+1];
  logic        xneg_r [DIV_STEPS+1];
  logic        yneg_r [DIV_STEPS+1];
  logic        dz_r   [DIV_STEPS+1];

  logic [NW-1:0] xn_w, yn_w;
  logic [63:0]   xhi_w, yhi_w;
  assign xn_w  = NW'(m_r[0]) << OUT_FRAC;
  assign yn_w  = NW'(m_r[1]) << OUT_FRAC;
  assign xhi_w = {{(97-NW){1'b0}}, xn_w[NW-1:33]};
  assign yhi_w = {{(97-NW){1'b0}}, yn_w[NW-1:33]};

  // Stage 5 is the divider entry, where a quotient of 2^33 or more is flagged
  // at once; the later stages do restoring division, one quotient bit per
  // stage for both coordinates.
  always_ff @(posedge clk) begin
    logic [64:0] tx, ty;
    logic        gx, gy;
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v4_r;
    d_r[0]    <= m_r[2];
    xrem_r[0] <= xhi_w;
    yrem_r[0] <= yhi_w;
    xlo_r[0]  <= xn_w[32:0];
    ylo_r[0]  <= yn_w[32:0];
    xq_r[0]   <= '0;
    yq_r[0]   <= '0;
    xpre_r[0] <= xhi_w >= m_r[2];
    ypre_r[0] <= yhi_w >= m_r[2];
    xneg_r[0] <= n_r[0] ^ n_r[2];
    yneg_r[0] <= n_r[1] ^ n_r[2];
    dz_r[0]   <= m_r[2] == 64'd0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      tx = {xrem_r[k], xlo_r[k][32]};
      ty = {yrem_r[k], ylo_r[k][32]};
      gx = tx >= {1'b0, d_r[k]};
      gy = ty >= {1'b0, d_r[k]};
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      xrem_r[k+1] <= gx ? 64'(tx - {1'b0, d_r[k]}) : tx[63:0];
      yrem_r[k+1] <= gy ? 64'(ty - {1'b0, d_r[k]}) : ty[63:0];
      xlo_r[k+1]  <= {xlo_r[k][31:0], 1'b0};
      ylo_r[k+1]  <= {ylo_r[k][31:0], 1'b0};
      xq_r[k+1]   <= {xq_r[k][31:0], gx};
      yq_r[k+1]   <= {yq_r[k][31:0], gy};
      d_r[k+1]    <= d_r[k];
      xpre_r[k+1] <= xpre_r[k];
      ypre_r[k+1] <= ypre_r[k];
      xneg_r[k+1] <= xneg_r[k];
      yneg_r[k+1] <= yneg_r[k];
      dz_r[k+1]   <= dz_r[k];
    end
  end

  // Saturation and sign for one coordinate.
  function automatic logic [32:0] finish(input logic [32:0] q, input logic pre,
                                         input logic neg);
    logic [32:0] lim;
    logic [32:0] v;
    logic        sat;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    sat = pre || (q > lim);
    v   = sat ? lim : q;
    v   = neg ? 33'(-v) : v;
    return {sat, v[31:0]};
  endfunction

  // Output stage: clamp, sign, zero divisor and swap.
  logic [32:0] fx_w, fy_w;
  assign fx_w = finish(xq_r[DIV_STEPS], xpre_r[DIV_STEPS], xneg_r[DIV_STEPS]);
  assign fy_w = finish(yq_r[DIV_STEPS], ypre_r[DIV_STEPS], yneg_r[DIV_STEPS]);

  logic               out_valid_r;
  logic signed [31:0] out_first_r, out_second_r;
  map_status_t        status_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[DIV_STEPS];
    if (dz_r[DIV_STEPS]) begin
      out_first_r  <= '0;
      out_second_r <= '0;
      status_r     <= ST_ZERO;
    end else begin
      out_first_r  <= swap_r ? fy_w[31:0] : fx_w[31:0];
      out_second_r <= swap_r ? fx_w[31:0] : fy_w[31:0];
      status_r     <= (fx_w[32] || fy_w[32]) ? ST_SAT : ST_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign map_status = status_r;

  // A result beat always follows a filled last divider stage.
  a_out_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_r[DIV_STEPS]))
    else $error("result beat without a divider stage behind it");

  // A zero divisor result carries zero coordinates.
  a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && map_status == ST_ZERO) |-> (out_first == 0 && out_second == 0))
    else $error("zero divisor result with nonzero coordinates");

  // The status never carries the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (map_status == ST_OK || map_status == ST_ZERO || map_status == ST_SAT))
    else $error("bad status code");

  // An accepted point fills the first stage on the next edge.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted point lost at entry");

endmodule

FILE: tb/sv/homography_point_map_test.sv
`timescale 1ns / 100ps

module homography_point_map_test;
  import hpm_pkg::*;

  localparam int IN_FRAC    = 8;
  localparam int OUT_FRAC   = 16;
  localparam int COEF_WIDTH = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int PIPE_DEPTH = 39;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [31:0] second;
    map_status_t        status;
  } mapped_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_first = '0;
  logic signed [31:0] in_second = '0;
  logic out_valid;
  logic signed [31:0] out_first;
  logic signed [31:0] out_second;
  map_status_t map_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Shadow copy of the coefficient registers.
  logic [63:0] mat_row0, mat_h02_h10, mat_h11_h12, mat_h20_h21;
  logic [31:0] mat_h22;
  logic        mat_swap;

  mapped_point_t pending_points[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  logic beat_seen;

  homography_point_map #(
    .IN_FRAC(IN_FRAC), .OUT_FRAC(OUT_FRAC), .COEF_WIDTH(COEF_WIDTH)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected mapping of one point under the current matrix.
  function automatic mapped_point_t project_point(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [66:0] ea, eb, h0, h1, h2, h3, h4, h5, h6, h7, h8;
    logic signed [66:0] nx, ny, dd;
    logic signed [98:0] wx, wy, wd, qx, qy;
    logic signed [31:0] rx, ry;
    mapped_point_t r;
    ea = 67'(a); eb = 67'(b);
    h0 = 67'($signed(mat_row0[63:32]));    h1 = 67'($signed(mat_row0[31:0]));
    h2 = 67'($signed(mat_h02_h10[63:32])); h3 = 67'($signed(mat_h02_h10[31:0]));
    h4 = 67'($signed(mat_h11_h12[63:32])); h5 = 67'($signed(mat_h11_h12[31:0]));
    h6 = 67'($signed(mat_h20_h21[63:32])); h7 = 67'($signed(mat_h20_h21[31:0]));
    h8 = 67'($signed(mat_h22));
    nx = h0 * ea + h1 * eb + (h2 <<< IN_FRAC);
    ny = h3 * ea + h4 * eb + (h5 <<< IN_FRAC);
    dd = h6 * ea + h7 * eb + (h8 <<< IN_FRAC);
    if (dd == 0) begin
      r.first = '0;
      r.second = '0;
      r.status = ST_ZERO;
      return r;
    end
    wx = 99'(nx); wy = 99'(ny); wd = 99'(dd);
    qx = (wx <<< OUT_FRAC) / wd;
    qy = (wy <<< OUT_FRAC) / wd;
    r.status = ST_OK;
    // Clamp each coordinate to 32 bits; either clamp flags the result.
    if (qx > 99'sd2147483647) begin
      rx = 32'h7FFF_FFFF; r.status = ST_SAT;
    end else if (qx < -99'sd2147483648) begin
      rx = 32'h8000_0000; r.status = ST_SAT;
    end else begin
      rx = qx[31:0];
    end
    if (qy > 99'sd2147483647) begin
      ry = 32'h7FFF_FFFF; r.status = ST_SAT;
    end else if (qy < -99'sd2147483648) begin
      ry = 32'h8000_0000; r.status = ST_SAT;
    end else begin
      ry = qy[31:0];
    end
    r.first  = mat_swap ? ry : rx;
    r.second = mat_swap ? rx : ry;
    return r;
  endfunction

  // Check each result beat against the oldest expected point.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result beat: %0d %0d status %0d",
                   out_first, out_second, map_status);
      end else begin
        mapped_point_t want;
        want = pending_points.pop_front();
        if (out_first !== want.first || out_second !== want.second ||
            map_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %0d %0d status %0d, got %0d %0d status %0d",
                     want.first, want.second, want.status,
                     out_first, out_second, map_status);
        end
      end
    end
  end

  // Watchdog on cycles that move no beat anywhere.
  always @(posedge clk) begin
    beat_seen = (start && !busy) || out_valid || (cfg_valid && cfg_ready);
    if (!rst_n || beat_seen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one point; start stays high after the beat so that back-to-back
  // points need no extra edge.
  task automatic send_point(logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    bit taken;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_first = a;
    in_second = b;
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (taken) pending_points = {pending_points, project_point(a, b)};
    end
    @(negedge clk);
  endtask

  // Wait until every expected point has arrived and the pipeline is empty.
  task automatic drain;
    start = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    bit taken;
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    case (idx)
      REG_ROW0_PAIR: mat_row0 = value;
      REG_H02_H10:   mat_h02_h10 = value;
      REG_H11_H12:   mat_h11_h12 = value;
      REG_H20_H21:   mat_h20_h21 = value;
      REG_H22:       mat_h22 = value[31:0];
      REG_SWAP:      mat_swap = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return 32'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [31:0] h22, logic swap_flag);
    write_reg(REG_ROW0_PAIR, r0);
    write_reg(REG_H02_H10, r1);
    write_reg(REG_H11_H12, r2);
    write_reg(REG_H20_H21, r3);
    write_reg(REG_H22, {32'd0, h22});
    write_reg(REG_SWAP, {63'd0, swap_flag});
  endtask

  // Identity after reset, with extreme and ordinary coordinates.
  task automatic test_reset_identity;
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sd0, 32'sd0);
    send_point(-32'sd1, 32'sd1);
    send_point(32'sd256, -32'sd256);
    send_point(32'sh0012_3456, -32'sh0065_4321);
    drain();
  endtask

  // Zero divisor, saturation both ways, swapped output and unused index.
  task automatic test_special_cases;
    load_matrix(IDENT_PAIR, 64'd0, IDENT_PAIR, 64'd0, 32'd0, 1'b0);
    send_point(32'sd1000, 32'sd2000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();
    load_matrix({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'd1},
                IDENT_PAIR, 64'd0, 32'd1, 1'b1);
    write_reg(REG_FRAC_BITS, 64'd31);
    send_point(32'sh7FFF_FFFF, 32'sd0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sd1, -32'sd1);
    drain();
    load_matrix({32'h0002_0000, 32'h0000_8000}, {32'hFFFF_0000, 32'h0001_0000},
                {32'h0003_0000, 32'h8000_0000},
                {32'h0000_0100, 32'hFFFF_FF00}, 32'h0001_0000, 1'b1);
    write_reg(REG_FRAC_BITS, 64'd0);
    write_reg(REG_UNUSED, {$urandom(), $urandom()});
    send_point(32'sd5000, -32'sd7000);
    send_point(-32'sd256, 32'sd512);
    send_point(32'sd256, 32'sd256);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    drain();
  endtask

  // Random matrices, a fresh one per phase, with random points.
  task automatic test_random_mapping(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_matrix({pick_coef(), pick_coef()}, {pick_coef(), pick_coef()},
                  {pick_coef(), pick_coef()}, {pick_coef(), pick_coef()},
                  pick_coef(), 1'($urandom_range(0, 1)));
      write_reg(REG_FRAC_BITS, {59'd0, 5'($urandom_range(0, 31))});
      for (int i = 0; i < per_phase; i++) begin
        send_point(pick_coord(), pick_coord());
        // Once per phase, halfway through, hold the sender until everything is back.
        if (i == per_phase / 2) begin
          start = 1'b0;
          while (pending_points.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    mat_row0 = IDENT_PAIR;
    mat_h02_h10 = '0;
    mat_h11_h12 = IDENT_PAIR;
    mat_h20_h21 = '0;
    mat_h22 = IDENT_ONE;
    mat_swap = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_identity();
    test_special_cases();
    test_random_mapping(7, 250);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hpm_pkg.sv
src/homography_point_map.sv
tb/sv/homography_point_map_test.sv
